>>> hw/rtl/adccal_pkg.sv
// Shared types and constants for the ADC calibration table unit.
// No dependencies; every other file of the block but adccal_ram imports this package.
`default_nettype none

package adccal_pkg;

    localparam int CODE_BITS   = 12;
    localparam int TABLE_DEPTH = 1 << CODE_BITS;
    localparam int ADDR_W      = CODE_BITS;
    localparam int CNT_W       = CODE_BITS + 1;
    localparam int ENTRY_W     = 16;
    localparam int SUM_W       = ENTRY_W + 1;
    localparam int STEP_W      = 12;
    localparam int GAIN_W      = 24;
    localparam int OFFSET_W    = 13;
    localparam int PROD_W      = STEP_W + GAIN_W;
    localparam int Q_FRAC      = 16;
    localparam int DIFF_W      = 24;
    localparam int CORR_W      = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = GAIN_W;

    typedef logic signed [ENTRY_W-1:0] entry_t;

    localparam entry_t SENTINEL = ENTRY_W'(-TABLE_DEPTH);
    localparam logic signed [DIFF_W-1:0] MIRROR_S = DIFF_W'(TABLE_DEPTH);
    localparam logic signed [DIFF_W-1:0] SAT_HI   = DIFF_W'((1 << (ENTRY_W - 1)) - 1);
    localparam logic signed [DIFF_W-1:0] SAT_LO   = DIFF_W'(-(1 << (ENTRY_W - 1)));
    localparam logic [GAIN_W-1:0]        GAIN_RESET = GAIN_W'(65536);

    typedef enum logic [1:0] {
        ACT_BEGIN   = 2'd0,
        ACT_SAMPLE  = 2'd1,
        ACT_FINISH  = 2'd2,
        ACT_CORRECT = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN   = 2'd0,
        REG_OFFSET = 2'd1,
        REG_INVERT = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_RD,
        ST_WR,
        ST_CLR,
        ST_FILL,
        ST_DONE
    } state_t;

    typedef struct packed {
        action_t           action;
        logic [STEP_W-1:0] sweep_step;
        logic [11:0]       adc_code;
    } in_word_t;

    typedef struct packed {
        logic signed [CORR_W-1:0] corrected_code;
        logic                     status;
        logic                     calibrated;
    } out_word_t;

    typedef struct packed {
        logic [GAIN_W-1:0]          gain_q16;
        logic signed [OFFSET_W-1:0] offset_step;
        logic                       invert;
    } cfg_t;

    typedef struct packed {
        entry_t                   sample_entry;
        logic signed [CORR_W-1:0] corr;
    } dp_res_t;

endpackage

`default_nettype wire

>>> hw/rtl/adc_calibration_table_unit.sv
// Top level of the ADC calibration table unit: configuration registers and
// the table RAM, sequencer and datapath. Uses adccal_pkg, adccal_ram,
// adccal_dp and adccal_ctrl.
//
//   channel  | ports                          | moves
//   ---------+--------------------------------+-------------------------------
//   input    | s_valid s_ready s_word         | one action word per handshake
//   result   | m_valid m_ready m_word         | one result word per action
//   config   | cfg_we cfg_idx cfg_wdata       | one register write per cycle
//
// Sample and correct pass through a table read and then a write state, in which
// a sample writes back through the single write port and the next word is
// accepted if the result register is free. Begin marks each entry empty, finish
// fills each empty entry from the one below, one entry per cycle; a finish
// without samples answers directly. Reset zeroes the table with s_ready low.
// A result waiting on m_ready holds only the word that would overwrite it.
`default_nettype none

module adc_calibration_table_unit (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire adccal_pkg::in_word_t             s_word,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output adccal_pkg::out_word_t                 m_word,
    input  wire logic                             cfg_we,
    input  wire logic [adccal_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [adccal_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    import adccal_pkg::*;

    cfg_t              cfg_reg;
    in_word_t          item;
    dp_res_t           dp_res;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    entry_t            ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    entry_t            ram_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_q16    <= GAIN_RESET;
            cfg_reg.offset_step <= '0;
            cfg_reg.invert      <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_idx))
                REG_GAIN:   cfg_reg.gain_q16    <= cfg_wdata[GAIN_W-1:0];
                REG_OFFSET: cfg_reg.offset_step <= cfg_wdata[OFFSET_W-1:0];
                REG_INVERT: cfg_reg.invert      <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    adccal_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word),
        .item      (item),
        .dp_res    (dp_res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    adccal_dp u_dp (
        .aclk      (aclk),
        .cfg       (cfg_reg),
        .item      (item),
        .old_entry (ram_rdata),
        .res       (dp_res)
    );

    adccal_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

>>> hw/rtl/adccal_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module adccal_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hw/rtl/adccal_dp.sv
// Arithmetic of the calibration table: expected code, saturated difference,
// averaging with the stored entry, and the corrected reading. Uses adccal_pkg.
`default_nettype none

module adccal_dp (
    input  wire logic              aclk,
    input  wire adccal_pkg::cfg_t     cfg,
    input  wire adccal_pkg::in_word_t item,
    input  wire adccal_pkg::entry_t   old_entry,
    output adccal_pkg::dp_res_t       res
);

    import adccal_pkg::*;

    logic [PROD_W-1:0]        prod_reg;
    logic [PROD_W-1:0]        prod_next;
    logic signed [DIFF_W-1:0] expect_v;
    logic signed [DIFF_W-1:0] mirror_v;
    logic signed [DIFF_W-1:0] diff_v;
    logic signed [DIFF_W-1:0] corr_v;
    logic signed [DIFF_W-1:0] corr_m;
    logic signed [DIFF_W-1:0] corr_o;
    logic signed [SUM_W-1:0]  sum_v;
    logic signed [SUM_W-1:0]  half_v;
    entry_t                   diff_sat;

    // The product is registered during the table read; the rest follows in the next cycle.
    assign prod_next = PROD_W'(item.sweep_step) * PROD_W'(cfg.gain_q16);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    always_comb begin
        expect_v = $signed(DIFF_W'(prod_reg[PROD_W-1:Q_FRAC])) - DIFF_W'(cfg.offset_step);
        mirror_v = cfg.invert ? MIRROR_S - expect_v : expect_v;
        diff_v   = $signed(DIFF_W'(item.adc_code)) - mirror_v;
        if (diff_v > SAT_HI) begin
            diff_sat = SAT_HI[ENTRY_W-1:0];
        end else if (diff_v < SAT_LO) begin
            diff_sat = SAT_LO[ENTRY_W-1:0];
        end else begin
            diff_sat = diff_v[ENTRY_W-1:0];
        end

        // Adding one to a negative sum makes the halving round toward zero.
        sum_v  = SUM_W'(old_entry) + SUM_W'(diff_sat);
        half_v = sum_v + $signed(SUM_W'(sum_v[SUM_W-1]));

        res.sample_entry = (old_entry == SENTINEL) ? diff_sat : half_v[ENTRY_W:1];

        corr_v   = $signed(DIFF_W'(item.adc_code)) - DIFF_W'(old_entry);
        corr_m   = cfg.invert ? MIRROR_S - corr_v : corr_v;
        corr_o   = corr_m + DIFF_W'(cfg.offset_step);
        res.corr = corr_o[CORR_W-1:0];
    end

endmodule

`default_nettype wire

>>> hw/rtl/adccal_ctrl.sv
// Sequencer of the calibration table: handshakes, table sweeps, flags and
// the output register. Uses adccal_pkg; drives the table RAM ports.
`default_nettype none

module adccal_ctrl (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire adccal_pkg::in_word_t    s_word,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output adccal_pkg::out_word_t        m_word,
    output adccal_pkg::in_word_t         item,
    input  wire adccal_pkg::dp_res_t     dp_res,
    output logic                         ram_we,
    output logic [adccal_pkg::ADDR_W-1:0] ram_waddr,
    output adccal_pkg::entry_t           ram_wdata,
    output logic [adccal_pkg::ADDR_W-1:0] ram_raddr,
    input  wire adccal_pkg::entry_t      ram_rdata
);

    import adccal_pkg::*;

    state_t                   state_reg;
    state_t                   state_next;
    state_t                   dispatch;
    logic [CNT_W-1:0]         cnt_reg;
    in_word_t                 item_reg;
    logic                     have_samples_reg;
    logic                     calib_reg;
    entry_t                   prev_reg;
    entry_t                   fill_val;
    logic signed [CORR_W-1:0] res_corr_reg;
    logic                     res_status_reg;
    logic                     m_valid_reg;
    out_word_t                m_word_reg;
    logic                     out_free;
    logic                     accept;
    logic                     out_load;
    logic                     sweep_last;
    logic                     fill_end;
    logic signed [CORR_W-1:0] corr_now;

    assign out_free   = !m_valid_reg || m_ready;
    assign accept     = s_valid && s_ready;
    assign sweep_last = (cnt_reg == CNT_W'(TABLE_DEPTH - 1));
    assign fill_end   = (cnt_reg == CNT_W'(TABLE_DEPTH));
    assign fill_val   = (ram_rdata == SENTINEL) ? prev_reg : ram_rdata;
    assign corr_now   = (item_reg.action == ACT_CORRECT) ? dp_res.corr : '0;

    always_comb begin
        case (s_word.action)
            ACT_BEGIN:  dispatch = ST_CLR;
            ACT_FINISH: dispatch = have_samples_reg ? ST_FILL : ST_DONE;
            default:    dispatch = ST_RD;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (sweep_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) state_next = dispatch;
            end
            ST_RD: begin
                state_next = ST_WR;
            end
            ST_WR, ST_DONE: begin
                if (out_free) begin
                    state_next = accept ? dispatch : ST_IDLE;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_CLR: begin
                if (sweep_last) state_next = ST_DONE;
            end
            ST_FILL: begin
                if (fill_end) state_next = ST_DONE;
            end
            default: state_next = ST_INIT;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        out_load  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = item_reg.adc_code[ADDR_W-1:0];
        ram_wdata = dp_res.sample_entry;
        ram_raddr = item_reg.adc_code[ADDR_W-1:0];
        case (state_reg)
            ST_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[ADDR_W-1:0];
                ram_wdata = '0;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_WR: begin
                s_ready  = out_free;
                out_load = out_free;
                ram_we   = (item_reg.action == ACT_SAMPLE);
            end
            ST_DONE: begin
                s_ready  = out_free;
                out_load = out_free;
            end
            ST_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[ADDR_W-1:0];
                ram_wdata = SENTINEL;
            end
            ST_FILL: begin
                ram_we    = (cnt_reg != '0);
                ram_waddr = ADDR_W'(cnt_reg - CNT_W'(1));
                ram_wdata = fill_val;
                ram_raddr = cnt_reg[ADDR_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_INIT;
            cnt_reg          <= '0;
            have_samples_reg <= 1'b0;
            calib_reg        <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                cnt_reg <= '0;
            end else if (state_reg == ST_INIT || state_reg == ST_CLR
                         || state_reg == ST_FILL) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (accept && s_word.action == ACT_BEGIN) begin
                have_samples_reg <= 1'b0;
            end else if (accept && s_word.action == ACT_SAMPLE) begin
                have_samples_reg <= 1'b1;
            end
            if (state_reg == ST_FILL && fill_end) begin
                calib_reg <= 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg       <= s_word;
            prev_reg       <= '0;
            res_corr_reg   <= '0;
            res_status_reg <= (s_word.action == ACT_FINISH) && !have_samples_reg;
        end else begin
            if (state_reg == ST_FILL && cnt_reg != '0) begin
                prev_reg <= fill_val;
            end
            if (state_reg == ST_WR) begin
                res_corr_reg <= corr_now;
            end
        end
        if (out_load) begin
            if (state_reg == ST_WR) begin
                m_word_reg.corrected_code <= corr_now;
                m_word_reg.status         <= 1'b0;
            end else begin
                m_word_reg.corrected_code <= res_corr_reg;
                m_word_reg.status         <= res_status_reg;
            end
            m_word_reg.calibrated <= calib_reg;
        end
    end

    assign item    = item_reg;
    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule

`default_nettype wire

>>> hw/rtl/adccal_checker.sv
// Port-level checks for adc_calibration_table_unit, attached by bind.
// Uses adccal_pkg; sees only the ports of the top level.
`default_nettype none

module adccal_checker (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_valid,
    input wire logic                  s_ready,
    input wire adccal_pkg::in_word_t  s_word,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire adccal_pkg::out_word_t m_word
);

    import adccal_pkg::*;

    // Reset leaves no result word pending.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word pending after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("result word dropped or changed while stalled");

    // Only a finish without samples reports an error, and it carries no reading.
    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.status |-> m_word.corrected_code == '0)
        else $error("error status with a nonzero reading");

    // Every action but finish goes on to a table state once it is accepted, and that state holds s_ready low.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_word.action != ACT_FINISH |=> !s_ready)
        else $error("input word accepted while the table is still busy");

endmodule

bind adc_calibration_table_unit adccal_checker u_adccal_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_word  (s_word),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_word  (m_word)
);

`default_nettype wire

>>> dv/adccal_table_checker.sv
// Checker for the ADC calibration table unit: tracks register writes, keeps its own
// copy of the correction table and compares every result word with its prediction.
// Depends on adccal_pkg for the word, action and register index types.
module adccal_table_checker
    import adccal_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_word_t              s_word,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_word_t             m_word,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    mismatch_count,
    output int                    outstanding
);

    entry_t                     cal_table [TABLE_DEPTH];
    logic                       have_samples;
    logic                       cal_done;
    logic [GAIN_W-1:0]          gain;
    logic signed [OFFSET_W-1:0] offset;
    logic                       inv;
    out_word_t                  owed_words [$];
    int                         mismatches = 0;
    int                         words_seen = 0;

    task automatic report(input string what);
        if (mismatches < 100) begin
            $display("checker: result word %0d: %s", words_seen, what);
        end
        mismatches++;
    endtask

    task automatic run_action(input in_word_t w, output out_word_t r);
        logic [PROD_W-1:0] prod;
        longint            target;
        longint            diff;
        longint            v;
        int                idx;
        r   = '0;
        idx = int'(w.adc_code) & (TABLE_DEPTH - 1);
        case (w.action)
            ACT_BEGIN: begin
                for (int i = 0; i < TABLE_DEPTH; i++) cal_table[i] = SENTINEL;
                have_samples = 1'b0;
            end
            ACT_SAMPLE: begin
                prod   = w.sweep_step * gain;
                target = longint'(prod >> Q_FRAC);
                target = target - longint'(offset);
                if (inv) begin
                    target = longint'(TABLE_DEPTH) - target;
                end
                diff = longint'(w.adc_code) - target;
                if (diff > 32767) begin
                    diff = 32767;
                end else if (diff < -32768) begin
                    diff = -32768;
                end
                if (cal_table[idx] == SENTINEL) begin
                    cal_table[idx] = entry_t'(diff);
                end else begin
                    cal_table[idx] = entry_t'((longint'(cal_table[idx]) + diff) / 2);
                end
                have_samples = 1'b1;
            end
            ACT_FINISH: begin
                if (!have_samples) begin
                    r.status = 1'b1;
                end else begin
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        if (cal_table[i] == SENTINEL) begin
                            cal_table[i] = (i == 0) ? entry_t'(0) : cal_table[i-1];
                        end
                    end
                    cal_done = 1'b1;
                end
            end
            default: begin
                v = longint'(w.adc_code) - longint'(cal_table[idx]);
                if (inv) begin
                    v = longint'(TABLE_DEPTH) - v;
                end
                v = v + longint'(offset);
                r.corrected_code = v[CORR_W-1:0];
            end
        endcase
        r.calibrated = cal_done;
    endtask

    always @(posedge aclk) begin
        out_word_t want;
        out_word_t got;
        if (!aresetn) begin
            for (int i = 0; i < TABLE_DEPTH; i++) cal_table[i] = '0;
            have_samples = 1'b0;
            cal_done     = 1'b0;
            gain         = GAIN_RESET;
            offset       = '0;
            inv          = 1'b0;
            owed_words.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_idx))
                    REG_GAIN:   gain   = cfg_wdata[GAIN_W-1:0];
                    REG_OFFSET: offset = cfg_wdata[OFFSET_W-1:0];
                    REG_INVERT: inv    = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                got = m_word;
                if (owed_words.size() == 0) begin
                    report("word arrived with nothing expected");
                end else begin
                    want = owed_words.pop_front();
                    if (got.corrected_code !== want.corrected_code) begin
                        report($sformatf("corrected_code expected %0d got %0d",
                                         want.corrected_code, got.corrected_code));
                    end
                    if (got.status !== want.status) begin
                        report($sformatf("status expected %0b got %0b",
                                         want.status, got.status));
                    end
                    if (got.calibrated !== want.calibrated) begin
                        report($sformatf("calibrated expected %0b got %0b",
                                         want.calibrated, got.calibrated));
                    end
                end
                words_seen++;
            end
            if (s_valid && s_ready) begin
                run_action(s_word, want);
                owed_words.push_back(want);
            end
        end
        outstanding    <= owed_words.size();
        mismatch_count <= mismatches;
    end

endmodule

>>> dv/tb_adc_calibration_table_unit.sv
// Testbench top for the ADC calibration table unit: clock, reset, register writes,
// bursty action stimulus and a stalling result receiver, plus the final verdict.
// Depends on adccal_pkg, adc_calibration_table_unit and adccal_table_checker.
module tb_adc_calibration_table_unit;
    import adccal_pkg::*;

    localparam int ITEM_GOAL   = 1750;
    localparam int CYCLE_LIMIT = 2_000_000;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    in_word_t              s_word    = '0;
    logic                  m_ready   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_ready;
    logic                  m_valid;
    out_word_t             m_word;
    int                    mismatch_count;
    int                    outstanding;
    int                    words_sent = 0;
    int                    burst_left = 0;

    adc_calibration_table_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    adccal_table_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_word         (s_word),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_word         (m_word),
        .cfg_we         (cfg_we),
        .cfg_idx        (cfg_idx),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // The receiver switches between steady, random and fixed-pattern stalling.
    initial begin
        int mode;
        int len;
        forever begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(16, 160);
            for (int k = 0; k < len; k++) begin
                @(posedge aclk);
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 1) == 1);
                    2:       m_ready <= ($urandom_range(0, 7) != 0);
                    default: m_ready <= ((k % 7) < 4);
                endcase
            end
        end
    end

    function automatic in_word_t make_word(action_t act, int step, int code);
        in_word_t w;
        w.action     = act;
        w.sweep_step = STEP_W'(step);
        w.adc_code   = 12'(code);
        return w;
    endfunction

    task automatic send_word(input in_word_t w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_word  <= w;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        words_sent++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_regs(input logic [GAIN_W-1:0] g, input logic signed [OFFSET_W-1:0] o,
                              input logic i);
        settle();
        cfg_we    <= 1'b1;
        cfg_idx   <= REG_GAIN;
        cfg_wdata <= g;
        @(posedge aclk);
        cfg_idx   <= REG_OFFSET;
        cfg_wdata <= CFG_DATA_W'($unsigned(o));
        @(posedge aclk);
        cfg_idx   <= REG_INVERT;
        cfg_wdata <= CFG_DATA_W'(i);
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    function automatic int pick_code(int base, int span);
        case ($urandom_range(0, 15))
            0:       return 0;
            1:       return 4095;
            2, 3:    return $urandom_range(0, 4095);
            default: return base + $urandom_range(0, span - 1);
        endcase
    endfunction

    // One calibration pass: begin, a sweep of samples, finish, then corrections.
    // A few passes are broken on purpose to exercise the unusual orders.
    task automatic run_sweep();
        int n_samples;
        int n_reads;
        int span;
        int base;
        int start;
        int stride;
        int step;
        logic swept;
        case ($urandom_range(0, 2))
            0:       span = 32;
            1:       span = 256;
            default: span = 4096;
        endcase
        base      = $urandom_range(0, 4096 - span);
        start     = $urandom_range(0, 4095);
        stride    = $urandom_range(1, 64);
        swept     = ($urandom_range(0, 1) == 1);
        n_samples = $urandom_range(20, 70);
        n_reads   = $urandom_range(10, 40);
        if ($urandom_range(0, 9) != 0) begin
            send_word(make_word(ACT_BEGIN, $urandom_range(0, 4095), $urandom_range(0, 4095)));
        end
        if ($urandom_range(0, 5) == 0) begin
            send_word(make_word(ACT_FINISH, $urandom_range(0, 4095), $urandom_range(0, 4095)));
        end
        for (int k = 0; k < n_samples; k++) begin
            step = swept ? (start + k * stride) % 4096 : $urandom_range(0, 4095);
            if ($urandom_range(0, 19) == 0) begin
                send_word(make_word(ACT_CORRECT, step, pick_code(base, span)));
            end else begin
                send_word(make_word(ACT_SAMPLE, step, pick_code(base, span)));
            end
        end
        if ($urandom_range(0, 11) != 0) begin
            send_word(make_word(ACT_FINISH, $urandom_range(0, 4095), $urandom_range(0, 4095)));
        end
        for (int k = 0; k < n_reads; k++) begin
            send_word(make_word(ACT_CORRECT, $urandom_range(0, 4095), pick_code(base, span)));
        end
    endtask

    initial begin
        int phase;
        logic [GAIN_W-1:0]          g;
        logic signed [OFFSET_W-1:0] o;
        logic                       i;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: finish with nothing sampled, then reads and samples on
        // the cleared table before any begin.
        send_word(make_word(ACT_FINISH, 0, 0));
        send_word(make_word(ACT_CORRECT, 0, 0));
        send_word(make_word(ACT_CORRECT, 4095, 4095));
        send_word(make_word(ACT_SAMPLE, 5, 7));
        send_word(make_word(ACT_SAMPLE, 4095, 4095));
        send_word(make_word(ACT_FINISH, 0, 0));
        send_word(make_word(ACT_CORRECT, 0, 7));
        send_word(make_word(ACT_BEGIN, 0, 0));
        send_word(make_word(ACT_FINISH, 0, 0));
        send_word(make_word(ACT_SAMPLE, 0, 1));

        // A gain of two makes the difference land exactly on the empty marker.
        write_regs(GAIN_W'(131072), '0, 1'b0);
        send_word(make_word(ACT_SAMPLE, 2048, 0));
        send_word(make_word(ACT_SAMPLE, 0, 0));
        send_word(make_word(ACT_SAMPLE, 2048, 2));

        // Huge expected values drive the difference into both saturation limits.
        write_regs('1, OFFSET_W'(-4096), 1'b0);
        send_word(make_word(ACT_SAMPLE, 4095, 100));
        write_regs('1, OFFSET_W'(4095), 1'b1);
        send_word(make_word(ACT_SAMPLE, 4095, 200));
        send_word(make_word(ACT_SAMPLE, 0, 4095));
        send_word(make_word(ACT_FINISH, 4095, 4095));
        send_word(make_word(ACT_CORRECT, 0, 0));
        send_word(make_word(ACT_CORRECT, 0, 100));
        send_word(make_word(ACT_CORRECT, 0, 200));
        send_word(make_word(ACT_CORRECT, 0, 150));
        send_word(make_word(ACT_CORRECT, 4095, 4095));

        phase = 0;
        while (words_sent < ITEM_GOAL) begin
            case (phase)
                0: begin g = GAIN_RESET; o = '0; i = 1'b0; end
                1: begin g = '1; o = OFFSET_W'(-4096); i = 1'b1; end
                2: begin g = '0; o = OFFSET_W'(4095); i = 1'b0; end
                3: begin g = GAIN_RESET; o = OFFSET_W'(-4096); i = 1'b1; end
                4: begin g = '0; o = '0; i = 1'b1; end
                5: begin g = '1; o = OFFSET_W'(4095); i = 1'b0; end
                6: begin g = GAIN_RESET; o = OFFSET_W'(4095); i = 1'b1; end
                7: begin
                    g = GAIN_W'($urandom_range(40000, 90000));
                    o = OFFSET_W'($urandom_range(0, 63));
                    i = 1'b0;
                end
                default: begin
                    g = GAIN_W'($urandom_range(0, 24'hFFFFFF));
                    o = OFFSET_W'($urandom_range(0, 8191));
                    i = ($urandom_range(0, 1) == 1);
                end
            endcase
            write_regs(g, o, i);
            repeat (2) run_sweep();
            phase++;
        end

        settle();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
